// ----- rtl/core/mfr_pkg.sv -----
// Shared types and constants of the metering frame receiver.
package mfr_pkg;

	// Frame layout
	localparam int unsigned ADDRESS_BYTES = 7;
	localparam int unsigned ADDR_CNT_W = 3;
	localparam logic [ADDR_CNT_W-1:0] ADDR_LAST = ADDR_CNT_W'(ADDRESS_BYTES - 1);

	// Result queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_MARK = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_END_MARK = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 2'd2;

	localparam logic [7:0] START_MARK_RST = 8'd104;
	localparam logic [7:0] END_MARK_RST = 8'd22;
	localparam logic [31:0] TIMEOUT_RST = 32'd100;

	// Input command
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [3:0] {
		FK_START = 4'd0,
		FK_TYPE = 4'd1,
		FK_ADDR = 4'd2,
		FK_CTRL = 4'd3,
		FK_LEN = 4'd4,
		FK_DATA = 4'd5,
		FK_SUM = 4'd6,
		FK_END = 4'd7,
		FK_ABORT = 4'd8
	} field_kind_t;

	typedef enum logic [2:0] {
		ST_BUSY = 3'd0,
		ST_GOOD = 3'd1,
		ST_SUM_BAD = 3'd2,
		ST_END_BAD = 3'd3,
		ST_TIMEOUT = 3'd4
	} frame_status_t;

	typedef enum logic [7:0] {
		PH_HUNT = 8'b0000_0001,
		PH_TYPE = 8'b0000_0010,
		PH_ADDR = 8'b0000_0100,
		PH_CTRL = 8'b0000_1000,
		PH_LEN = 8'b0001_0000,
		PH_DATA = 8'b0010_0000,
		PH_SUM = 8'b0100_0000,
		PH_END = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] open_byte;
		logic [7:0] close_byte;
		logic [31:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		field_kind_t field_kind;
		frame_status_t frame_status;
		logic last;
	} result_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ----- rtl/core/mfr_front.sv -----
// Front end: frame parser, checksum and idle timer; classifies each beat.
module mfr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic cmd,
	input  logic [7:0] rx_byte,
	input  mfr_pkg::cfg_t cfg,
	output logic res_valid,
	output mfr_pkg::result_t res
);

	mfr_pkg::phase_t phase_q, phase_d;
	logic [mfr_pkg::ADDR_CNT_W-1:0] addr_cnt_q, addr_cnt_d;
	logic [7:0] data_rem_q, data_rem_d;
	logic [7:0] sum_q, sum_d;
	logic [31:0] idle_q, idle_d;
	logic [31:0] idle_inc;
	logic [7:0] sum_add;

	assign idle_inc = (idle_q == '1) ? idle_q : idle_q + 32'd1;
	assign sum_add = sum_q + rx_byte;

	always_comb begin
		phase_d = phase_q;
		addr_cnt_d = addr_cnt_q;
		data_rem_d = data_rem_q;
		sum_d = sum_q;
		idle_d = idle_q;
		res_valid = 1'b0;
		res.out_byte = rx_byte;
		res.field_kind = mfr_pkg::FK_START;
		res.frame_status = mfr_pkg::ST_BUSY;
		res.last = 1'b0;
		if (cmd == mfr_pkg::CMD_TICK) begin
			idle_d = idle_inc;
			if (idle_inc > cfg.timeout_ticks) begin
				idle_d = '0;
				if (phase_q != mfr_pkg::PH_HUNT) begin
					phase_d = mfr_pkg::PH_HUNT;
					addr_cnt_d = '0;
					data_rem_d = '0;
					sum_d = '0;
					res_valid = 1'b1;
					res.out_byte = '0;
					res.field_kind = mfr_pkg::FK_ABORT;
					res.frame_status = mfr_pkg::ST_TIMEOUT;
					res.last = 1'b1;
				end
			end
		end else begin
			idle_d = '0;
			sum_d = sum_add;
			res_valid = 1'b1;
			unique case (phase_q)
				mfr_pkg::PH_HUNT: begin
					if (rx_byte != cfg.open_byte) begin
						sum_d = '0;
						res_valid = 1'b0;
					end else begin
						sum_d = rx_byte;
						addr_cnt_d = '0;
						phase_d = mfr_pkg::PH_TYPE;
					end
				end
				mfr_pkg::PH_TYPE: begin
					res.field_kind = mfr_pkg::FK_TYPE;
					addr_cnt_d = '0;
					phase_d = mfr_pkg::PH_ADDR;
				end
				mfr_pkg::PH_ADDR: begin
					res.field_kind = mfr_pkg::FK_ADDR;
					if (addr_cnt_q >= mfr_pkg::ADDR_LAST) begin
						addr_cnt_d = '0;
						phase_d = mfr_pkg::PH_CTRL;
					end else begin
						addr_cnt_d = addr_cnt_q + 1'b1;
					end
				end
				mfr_pkg::PH_CTRL: begin
					res.field_kind = mfr_pkg::FK_CTRL;
					phase_d = mfr_pkg::PH_LEN;
				end
				mfr_pkg::PH_LEN: begin
					res.field_kind = mfr_pkg::FK_LEN;
					data_rem_d = rx_byte;
					phase_d = (rx_byte != 8'd0) ? mfr_pkg::PH_DATA : mfr_pkg::PH_SUM;
				end
				mfr_pkg::PH_DATA: begin
					res.field_kind = mfr_pkg::FK_DATA;
					data_rem_d = data_rem_q - 8'd1;
					if (data_rem_q == 8'd1) phase_d = mfr_pkg::PH_SUM;
				end
				mfr_pkg::PH_SUM: begin
					res.field_kind = mfr_pkg::FK_SUM;
					if (rx_byte != sum_q) begin
						phase_d = mfr_pkg::PH_HUNT;
						sum_d = '0;
						res.frame_status = mfr_pkg::ST_SUM_BAD;
						res.last = 1'b1;
					end else begin
						phase_d = mfr_pkg::PH_END;
					end
				end
				default: begin
					// end mark slot, also recovers from any stray code
					res.field_kind = mfr_pkg::FK_END;
					phase_d = mfr_pkg::PH_HUNT;
					sum_d = '0;
					addr_cnt_d = '0;
					data_rem_d = '0;
					res.last = 1'b1;
					res.frame_status = (rx_byte == cfg.close_byte) ?
						mfr_pkg::ST_GOOD : mfr_pkg::ST_END_BAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mfr_pkg::PH_HUNT;
			addr_cnt_q <= '0;
			data_rem_q <= '0;
			sum_q <= '0;
			idle_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			addr_cnt_q <= addr_cnt_d;
			data_rem_q <= data_rem_d;
			sum_q <= sum_d;
			idle_q <= idle_d;
		end
	end

endmodule

// ----- rtl/core/mfr_queue.sv -----
// Small result FIFO that decouples the parser from the output stage.
module mfr_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  mfr_pkg::result_t push_data,
	input  logic pop,
	output mfr_pkg::result_t head,
	output mfr_pkg::queue_status_t status
);

	mfr_pkg::result_t mem_q [mfr_pkg::QUEUE_DEPTH];
	logic [mfr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [mfr_pkg::QCNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign status.count = count_q;
	assign status.full = (count_q == mfr_pkg::QCNT_W'(mfr_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop = pop && !status.empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/mfr_back.sv -----
// Back end: output register that presents one result beat at a time.
module mfr_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  mfr_pkg::result_t q_head,
	output logic q_pop,
	output logic out_valid,
	input  logic out_ready,
	output mfr_pkg::result_t out_res
);

	logic valid_q;
	mfr_pkg::result_t res_q;

	// refill when the register is empty or its beat leaves this cycle
	assign q_pop = !q_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) res_q <= q_head;
	end

endmodule

// ----- rtl/core/metering_frame_receiver.sv -----
// Top level of the metering frame receiver: config registers, parser, queue, output stage.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  in      | in  | in_valid / in_ready  | cmd, rx_byte
//  out     | out | out_valid / out_ready| out_byte, field_kind, frame_status, last
//  cfg     | in  | cfg_we (no wait)     | cfg_index, cfg_data
//
// One input beat per cycle while in_ready is high. A beat is parsed in the cycle it is
// taken; its result goes into the queue, then into the output register behind out_valid.
// in_ready drops only while the four-entry result queue is full, so a stalled
// consumer backs up the input after four results plus the one held at the output.
// Reset puts the parser in the hunt phase, empties the queue and loads the
// register defaults (start 104, end 22, timeout 100); no clearing pass.
module metering_frame_receiver (
	input  logic clk,
	input  logic arst_n,
	// configuration
	input  logic cfg_we,
	input  logic [mfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mfr_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic in_valid,
	output logic in_ready,
	input  logic cmd,
	input  logic [7:0] rx_byte,
	// output channel
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_byte,
	output logic [3:0] field_kind,
	output logic [2:0] frame_status,
	output logic last
);

	mfr_pkg::cfg_t cfg_q;
	logic accept;
	logic res_valid;
	mfr_pkg::result_t res;
	mfr_pkg::result_t q_head;
	mfr_pkg::queue_status_t q_stat;
	logic q_pop;
	logic q_push;
	mfr_pkg::result_t out_res;

	// Register file; index 3 is unused and writes to it drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_byte <= mfr_pkg::START_MARK_RST;
			cfg_q.close_byte <= mfr_pkg::END_MARK_RST;
			cfg_q.timeout_ticks <= mfr_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfr_pkg::CFG_START_MARK: cfg_q.open_byte <= cfg_data[7:0];
				mfr_pkg::CFG_END_MARK: cfg_q.close_byte <= cfg_data[7:0];
				mfr_pkg::CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// A beat is taken whenever the queue has room for its possible result.
	assign in_ready = !q_stat.full;
	assign accept = in_valid && in_ready;
	assign q_push = accept && res_valid;

	mfr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.cmd(cmd),
		.rx_byte(rx_byte),
		.cfg(cfg_q),
		.res_valid(res_valid),
		.res(res)
	);

	mfr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(res),
		.pop(q_pop),
		.head(q_head),
		.status(q_stat)
	);

	mfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_stat.empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res(out_res)
	);

	assign out_byte = out_res.out_byte;
	assign field_kind = out_res.field_kind;
	assign frame_status = out_res.frame_status;
	assign last = out_res.last;

	// A frame-ending beat always carries a final status, and only it does.
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (frame_status != mfr_pkg::ST_BUSY)))
		else $error("last and frame status disagree");

	// Timeout status appears exactly on abort beats.
	a_abort_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((field_kind == mfr_pkg::FK_ABORT) ==
			(frame_status == mfr_pkg::ST_TIMEOUT)))
		else $error("abort kind without timeout status");

	// Queue occupancy tracks a lone push.
	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
		else $error("queue count did not follow push");

endmodule
